@@ src/asmdu_pkg.sv @@
`default_nettype none
package asmdu_pkg;

  localparam int DATA_W      = 32;
  localparam int MUL_W       = 16;
  localparam int KIND_W      = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DCNT_W      = $clog2(DATA_W + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

@@ src/asmdu_front.sv @@
`default_nettype none
module asmdu_front
  import asmdu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t in_item,
  output logic       head_valid,
  output item_t      head_item,
  input  wire logic  take
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_take;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        count <= count + 1'b1;
      end else if (!do_push && do_take) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ src/asmdu_div.sv @@
`default_nettype none
module asmdu_div
  import asmdu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  input  wire logic              ack,
  output div_status_t            status,
  output logic [DATA_W-1:0]      quotient
);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // One restoring step per cycle; a zero divisor never fails a trial.
  assign shifted  = {rem, quo[DATA_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;
  assign status   = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DCNT_W'(DATA_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (ack) begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ src/asmdu_back.sv @@
`default_nettype none
module asmdu_back
  import asmdu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         head_valid,
  input  wire item_t        head_item,
  output logic              take,
  output logic              empty,
  input  wire logic         pop,
  output logic [DATA_W-1:0] result_value
);

  logic                  out_valid;
  logic [DATA_W-1:0]     out_data;
  logic                  out_free;
  logic                  is_div;
  logic                  take_alu;
  logic                  div_start;
  logic                  div_ack;
  div_status_t           div_st;
  logic [DATA_W-1:0]     div_q;
  logic [2*MUL_W-1:0]    product;
  logic [DATA_W-1:0]     alu_value;

  assign out_free  = !out_valid || pop;
  assign is_div    = (head_item.kind == KIND_DIV);
  assign div_ack   = div_st.done && out_free;
  // A divide in flight keeps later items in the queue so results stay in order.
  assign take_alu  = head_valid && !is_div && !div_st.busy && !div_st.done && out_free;
  assign div_start = head_valid && is_div && !div_st.busy && !div_st.done;
  assign take      = take_alu || div_start;

  assign product = head_item.a[MUL_W-1:0] * head_item.b[MUL_W-1:0];

  always_comb begin
    case (head_item.kind)
      KIND_ADD: alu_value = head_item.a + head_item.b;
      KIND_SUB: alu_value = head_item.a + (~head_item.b + 1'b1);
      KIND_MUL: alu_value = DATA_W'(product);
      default:  alu_value = '0;
    endcase
  end

  asmdu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (head_item.a),
    .divisor  (head_item.b),
    .ack      (div_ack),
    .status   (div_st),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_alu || div_ack) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ack) begin
      out_data <= div_q;
    end else if (take_alu) begin
      out_data <= alu_value;
    end
  end

  assign empty        = !out_valid;
  assign result_value = out_data;

endmodule
`default_nettype wire

@@ src/add_sub_mul_div_unit.sv @@
`default_nettype none
// Channel   Direction  Handshake     Payload
// input     in         push / full   kind, operand_a, operand_b
// result    out        empty / pop   result_value
//
// Add, subtract and multiply are computed combinationally in the execute stage,
// so they sustain one transfer per cycle while the result register is free or
// popped. Divide runs in an iterative restoring divider that retires one
// quotient bit per cycle and then hands over the result; items behind it wait in the input queue meanwhile.
// Reset (synchronous, rst high) empties the queue and the result register.
// The input queue keeps accepting while a result waits to be popped.
module add_sub_mul_div_unit
  import asmdu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [DATA_W-1:0] operand_a,
  input  wire logic [DATA_W-1:0] operand_b,
  output logic                   empty,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      result_value
);

  item_t in_item;
  item_t head_item;
  logic  head_valid;
  logic  take;

  // Pack the incoming fields into one queue entry.
  assign in_item = '{kind: kind_t'(kind), a: operand_a, b: operand_b};

  // Front: queue that decouples acceptance from execution.
  asmdu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .take       (take)
  );

  // Back: execute stage, divider and result register.
  asmdu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .take         (take),
    .empty        (empty),
    .pop          (pop),
    .result_value (result_value)
  );

endmodule
`default_nettype wire
